### rtl/dbba_pkg.sv
// Shared types and constants for the double-buffered bump allocator.
package dbba_pkg;

  localparam int SIZE_W          = 24;
  localparam int ALOG_W          = 4;
  localparam int ADDR_W          = 32;
  localparam int CAP_W           = 25;
  localparam int OFF_W           = 26;
  localparam int CNT_W           = 21;
  localparam int AMASK_W         = 16;
  localparam int NUM_BUF         = 2;
  localparam int BASE_ALIGN      = 16;
  localparam int BASE_ALIGN_LOG2 = 4;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USED_W = ADDR_W + 1 + OFF_W + OFF_W + CNT_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam int Q_DEPTH = 2;
  localparam int QPTR_W  = $clog2(Q_DEPTH);
  localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1) << SIZE_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_BASE_A   = 2'd1,
    CFG_BASE_B   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_GRANT = 2'd0,
    ST_OOM   = 2'd1,
    ST_FRAME = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    KIND_ALLOC  = 2'd0,
    KIND_FRAME  = 2'd1,
    KIND_REJECT = 2'd2
  } kind_t;

  // Decoded item handed from front to back.
  typedef struct packed {
    kind_t               kind;
    logic [OFF_W-1:0]    need;      // padded size
    logic                fits;      // need <= capacity
    logic [CAP_W-1:0]    cap_left;  // capacity - need, valid when fits
    logic [AMASK_W-1:0]  amask;     // alignment - 1
    logic [ADDR_W-1:0]   bpm_a;     // base a + amask
    logic [ADDR_W-1:0]   bpm_b;     // base b + amask
  } item_t;

endpackage

### rtl/dbba_front.sv
// Front end: config registers, item intake and decode into a queue entry.
module dbba_front (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [dbba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbba_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dbba_pkg::IN_DATA_W-1:0] in_tdata,
  input  logic                           in_tuser,
  output logic                           f_valid,
  input  logic                           f_ready,
  output dbba_pkg::item_t                f_item
);
  import dbba_pkg::*;

  logic [CAP_W-1:0]  cap_r;
  logic [ADDR_W-1:0] base_a_r;
  logic [ADDR_W-1:0] base_b_r;

  logic   fv_r, fv_nxt;
  item_t  item_r, item_nxt;

  logic [SIZE_W-1:0]  size;
  logic [ALOG_W-1:0]  alog;
  logic [OFF_W-1:0]   rounded;
  logic [AMASK_W-1:0] pow;
  logic [OFF_W-1:0]   pad;
  logic               load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r    <= CAP_RESET;
      base_a_r <= '0;
      base_b_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY: cap_r    <= cfg_wdata[CAP_W-1:0];
        CFG_BASE_A:   base_a_r <= cfg_wdata[ADDR_W-1:0];
        CFG_BASE_B:   base_b_r <= cfg_wdata[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  assign size      = in_tdata[SIZE_W-1:0];
  assign alog      = in_tdata[SIZE_W +: ALOG_W];
  assign in_tready = !fv_r || f_ready;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    rounded = (OFF_W'(size) + OFF_W'(BASE_ALIGN - 1)) & ~OFF_W'(BASE_ALIGN - 1);
    pow     = AMASK_W'(1) << alog;
    pad     = (alog > ALOG_W'(BASE_ALIGN_LOG2)) ? OFF_W'(pow - AMASK_W'(BASE_ALIGN)) : '0;

    item_nxt.need     = rounded + pad;
    item_nxt.fits     = item_nxt.need <= OFF_W'(cap_r);
    item_nxt.cap_left = cap_r - item_nxt.need[CAP_W-1:0];
    item_nxt.amask    = pow - AMASK_W'(1);
    item_nxt.bpm_a    = base_a_r + ADDR_W'(item_nxt.amask);
    item_nxt.bpm_b    = base_b_r + ADDR_W'(item_nxt.amask);
    if (in_tuser)
      item_nxt.kind = KIND_FRAME;
    else if (CAP_W'(size) > cap_r)
      item_nxt.kind = KIND_REJECT;
    else
      item_nxt.kind = KIND_ALLOC;

    if (load)
      fv_nxt = 1'b1;
    else if (f_ready)
      fv_nxt = 1'b0;
    else
      fv_nxt = fv_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n)
      fv_r <= 1'b0;
    else
      fv_r <= fv_nxt;
  end

  always_ff @(posedge clk) begin
    if (load)
      item_r <= item_nxt;
  end

  assign f_valid = fv_r;
  assign f_item  = item_r;

endmodule

### rtl/dbba_queue.sv
// Short queue of decoded items between front and back.
module dbba_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  dbba_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop_ready,
  output dbba_pkg::item_t pop_item
);
  import dbba_pkg::*;

  item_t              mem [Q_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               push, pop;

  assign push_ready = cnt_r != QCNT_W'(Q_DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push)
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    if (pop)
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    if (push && !pop)
      cnt_nxt = cnt_r + QCNT_W'(1);
    else if (pop && !push)
      cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push)
      mem[wr_ptr_r] <= push_item;
  end

endmodule

### rtl/dbba_back.sv
// Back end: buffer state, offset bump, grant decision and result register.
module dbba_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  output logic                            q_ready,
  input  dbba_pkg::item_t                 q_item,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dbba_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [1:0]                      out_tuser
);
  import dbba_pkg::*;

  logic               cur_r;
  logic [OFF_W-1:0]   fill_r  [NUM_BUF];
  logic [OFF_W-1:0]   peak_r  [NUM_BUF];
  logic [CNT_W-1:0]   tally_r [NUM_BUF];

  logic                  ov_r;
  logic [OUT_DATA_W-1:0] odata_r, odata_nxt;
  status_t               ouser_r, status_nxt;

  logic               pop;
  logic               idx;
  logic [OFF_W-1:0]   old, pk;
  logic [CNT_W-1:0]   tl;
  logic [OFF_W:0]     sum;
  logic [OFF_W-1:0]   sum_sat;
  logic               ok;
  logic [ADDR_W-1:0]  bsel, addr_t, granted;
  logic [OFF_W-1:0]   fill_new, peak_new;
  logic [CNT_W-1:0]   tally_new;
  logic [ADDR_W-1:0]  addr_new;

  assign q_ready = !ov_r || out_tready;
  assign pop     = q_valid && q_ready;

  always_comb begin
    // frame items work on the other buffer, which then becomes current
    idx     = (q_item.kind == KIND_FRAME) ? ~cur_r : cur_r;
    old     = fill_r[idx];
    pk      = peak_r[idx];
    tl      = tally_r[idx];
    sum     = {1'b0, old} + {1'b0, q_item.need};
    sum_sat = sum[OFF_W] ? '1 : sum[OFF_W-1:0];
    ok      = q_item.fits && (old <= OFF_W'(q_item.cap_left));
    bsel    = cur_r ? q_item.bpm_b : q_item.bpm_a;
    addr_t  = bsel + ADDR_W'(old);
    granted = addr_t & ~ADDR_W'(q_item.amask);

    fill_new   = old;
    peak_new   = pk;
    tally_new  = tl;
    addr_new   = '0;
    status_nxt = ST_OOM;
    unique case (q_item.kind)
      KIND_FRAME: begin
        fill_new   = '0;
        peak_new   = (old > pk) ? old : pk;
        tally_new  = '0;
        status_nxt = ST_FRAME;
      end
      KIND_ALLOC: begin
        fill_new = sum_sat;
        if (ok) begin
          tally_new  = (tl == '1) ? tl : tl + CNT_W'(1);
          addr_new   = granted;
          status_nxt = ST_GRANT;
        end
      end
      default: ;
    endcase

    odata_nxt = OUT_DATA_W'({tally_new, peak_new, fill_new, idx, addr_new});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= 1'b0;
      for (int i = 0; i < NUM_BUF; i++) begin
        fill_r[i]  <= '0;
        peak_r[i]  <= '0;
        tally_r[i] <= '0;
      end
      ov_r <= 1'b0;
    end else begin
      if (pop) begin
        cur_r        <= idx;
        fill_r[idx]  <= fill_new;
        peak_r[idx]  <= peak_new;
        tally_r[idx] <= tally_new;
        ov_r         <= 1'b1;
      end else if (out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      odata_r <= odata_nxt;
      ouser_r <= status_nxt;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;

endmodule

### rtl/double_buffered_bump_allocator.sv
// Top level of the double-buffered bump allocator.
//
//   channel | dir | handshake             | payload
//   in_     | in  | in_tvalid/in_tready   | tuser: operation; tdata: size, align_log2
//   out_    | out | out_tvalid/out_tready | tuser: status; tdata: address .. grant_count
//   cfg_    | in  | cfg_we                | cfg_index, cfg_wdata
//
// One item per cycle sustained while out_tready holds; a result passes the front register,
// the queue and the result register. The back end's offset bump on each pop sets the rate.
// Reset (synchronous, rst_n low) clears both buffers and selects buffer zero;
// capacity returns to 2^24 and both bases to zero.
// A stalled output backs up the two-entry queue and then the front register.
module double_buffered_bump_allocator (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dbba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [23:0] request_size, [27:24] align_log2, [31:28] zero
  input  logic [dbba_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] operation
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] address, [32] buffer_index, [58:33] used_bytes, [84:59] peak_bytes,
  // [105:85] grant_count, [111:106] zero
  output logic [dbba_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [1:0]                       out_tuser
);
  import dbba_pkg::*;

  logic  f_valid, f_ready;
  item_t f_item;
  logic  q_valid, q_ready;
  item_t q_item;

  dbba_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_item    (f_item)
  );

  dbba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_item  (f_item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_item   (q_item)
  );

  dbba_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

### rtl/dbba_checker.sv
// Port-level checks for the double-buffered bump allocator, bound to the top level.
module dbba_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [dbba_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]                      out_tuser
);
  import dbba_pkg::*;

  localparam int USED_LO = ADDR_W + 1;
  localparam int CNT_LO  = ADDR_W + 1 + OFF_W + OFF_W;

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser == ST_GRANT || out_tuser == ST_OOM || out_tuser == ST_FRAME))
    else $error("result status outside defined codes");

  a_no_addr_unless_grant: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_GRANT |-> out_tdata[ADDR_W-1:0] == '0)
    else $error("address nonzero on a non-granted result");

  a_frame_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_FRAME
      |-> out_tdata[USED_LO +: OFF_W] == '0 && out_tdata[CNT_LO +: CNT_W] == '0)
    else $error("frame start did not clear offset and count");

  a_grant_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == ST_GRANT |-> out_tdata[CNT_LO +: CNT_W] != '0)
    else $error("granted result shows zero grant count");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind double_buffered_bump_allocator dbba_checker u_dbba_checker (.*);

### bench/bump_alloc_checker.sv
// Result checker for the double-buffered bump allocator: predicts each result and compares it.
module bump_alloc_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [dbba_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dbba_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [dbba_pkg::IN_DATA_W-1:0]   in_tdata,
  input  logic                             in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [dbba_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic [1:0]                       out_tuser,
  output int                               fail_count,
  output int                               due_count
);
  import dbba_pkg::*;

  localparam logic [63:0] FILL_TOP = (64'd1 << OFF_W) - 1;

  typedef struct packed {
    logic [ADDR_W-1:0] address;
    status_t           status;
    logic              buf_idx;
    logic [OFF_W-1:0]  used;
    logic [OFF_W-1:0]  peak;
    logic [CNT_W-1:0]  grants;
  } alloc_result_t;

  // allocator state as the block should hold it
  logic              cur_buf;
  logic [OFF_W-1:0]  fill_off [NUM_BUF];
  logic [OFF_W-1:0]  peak_off [NUM_BUF];
  logic [CNT_W-1:0]  tally [NUM_BUF];
  logic [CAP_W-1:0]  cap;
  logic [ADDR_W-1:0] base_a;
  logic [ADDR_W-1:0] base_b;

  alloc_result_t pending_results [$];
  int n_fail = 0;
  int n_due = 0;
  int n_results = 0;

  assign fail_count = n_fail;
  assign due_count  = n_due;

  task automatic report(input string msg);
    if (n_fail < 40)
      $display("checker: result %0d: %s", n_results, msg);
    n_fail++;
  endtask

  task automatic compare_field(input string name, input logic [63:0] seen,
                               input logic [63:0] wanted);
    if (seen !== wanted)
      report($sformatf("%s is 0x%0h, expected 0x%0h", name, seen, wanted));
  endtask

  function automatic alloc_result_t allocate_or_flip(input logic op,
                                                     input logic [SIZE_W-1:0] size,
                                                     input logic [ALOG_W-1:0] alog);
    alloc_result_t r;
    logic [63:0] align, need, old, total, raw, m;
    logic b;
    r = '0;
    b = cur_buf;
    if (op) begin
      b = ~b;
      cur_buf = b;
      if (fill_off[b] > peak_off[b]) peak_off[b] = fill_off[b];
      fill_off[b] = '0;
      tally[b] = '0;
      r.status = ST_FRAME;
    end else if (64'(size) > 64'(cap)) begin
      // oversized: offset untouched
      r.status = ST_OOM;
    end else begin
      align = 64'd1 << alog;
      need = ((64'(size) + BASE_ALIGN - 1) / BASE_ALIGN) * BASE_ALIGN;
      if (align > BASE_ALIGN) need = need + align - BASE_ALIGN;
      old = 64'(fill_off[b]);
      total = old + need;
      // offset moves even when the grant fails
      fill_off[b] = (total > FILL_TOP) ? FILL_TOP[OFF_W-1:0] : total[OFF_W-1:0];
      if (need > 64'(cap) || old > 64'(cap) - need) begin
        r.status = ST_OOM;
      end else begin
        raw = 64'(b ? base_b : base_a) + old;
        m = align - 1;
        r.address = ADDR_W'((raw + m) & ~m);
        if (tally[b] != {CNT_W{1'b1}}) tally[b] = tally[b] + 1'b1;
        r.status = ST_GRANT;
      end
    end
    r.buf_idx = b;
    r.used = fill_off[b];
    r.peak = peak_off[b];
    r.grants = tally[b];
    return r;
  endfunction

  always @(posedge clk) begin : watch
    alloc_result_t want;
    if (!rst_n) begin
      cur_buf = 1'b0;
      for (int i = 0; i < NUM_BUF; i++) begin
        fill_off[i] = '0;
        peak_off[i] = '0;
        tally[i] = '0;
      end
      cap = CAP_RESET;
      base_a = '0;
      base_b = '0;
      pending_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_CAPACITY: cap = cfg_wdata[CAP_W-1:0];
          CFG_BASE_A:   base_a = cfg_wdata[ADDR_W-1:0];
          CFG_BASE_B:   base_b = cfg_wdata[ADDR_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(allocate_or_flip(in_tuser, in_tdata[23:0],
                                                   in_tdata[27:24]));
      if (out_tvalid && out_tready) begin
        n_results++;
        if (pending_results.size() == 0) begin
          report("result arrived with nothing expected");
        end else begin
          want = pending_results.pop_front();
          compare_field("address", out_tdata[31:0], want.address);
          compare_field("status", out_tuser, want.status);
          compare_field("buffer_index", out_tdata[32], want.buf_idx);
          compare_field("used_bytes", out_tdata[58:33], want.used);
          compare_field("peak_bytes", out_tdata[84:59], want.peak);
          compare_field("grant_count", out_tdata[105:85], want.grants);
        end
      end
    end
    n_due = pending_results.size();
  end

endmodule

### bench/testbench.sv
// Top of the allocator testbench: clock, reset, stimulus, register phases and verdict.
module testbench;
  import dbba_pkg::*;

  localparam int CYCLE_LIMIT = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [1:0]            out_tuser;

  int fail_count;
  int due_count;

  bit     quiet = 1'b0;
  int     gap_pct = 0;
  longint cap_now = 64'd16777216;
  int     n_items = 0;
  int     n_frames = 0;
  int     n_writes = 0;
  int     cycle_count = 0;

  double_buffered_bump_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  bump_alloc_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .fail_count(fail_count), .due_count(due_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("testbench: timeout after %0d cycles", cycle_count);
      $display("testbench: errors");
      $finish;
    end
  end

  // result side: ready bursts with random stalls, none once quiet
  initial begin
    @(posedge clk);
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      if (!quiet && $urandom_range(0, 3) != 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
    end
  end

  // called at a rising edge; returns at the edge where the item was taken
  task automatic send_item(input logic op, input logic [SIZE_W-1:0] size,
                           input logic [ALOG_W-1:0] alog);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {4'b0, alog, size};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_items++;
    if (op) n_frames++;
  endtask

  task automatic send_random();
    longint s;
    int k;
    logic op;
    logic [ALOG_W-1:0] al;
    op = ($urandom_range(0, 11) == 0);
    k = $urandom_range(0, 9);
    if (k <= 4)
      s = $urandom_range(0, 300);
    else if (k <= 6)
      s = $urandom_range(0, 32'(cap_now / 8));
    else if (k == 7)
      s = (cap_now >= 64) ? cap_now - $urandom_range(0, 64) : $urandom_range(0, 32'(cap_now));
    else if (k == 8)
      s = $urandom() & 32'hFFFFFF;
    else
      s = cap_now + $urandom_range(1, 64);  // oversized when it fits the field
    if (s > 64'hFFFFFF) s = 64'hFFFFFF;
    al = ($urandom_range(0, 3) == 0) ? ALOG_W'($urandom_range(0, 15))
                                     : ALOG_W'($urandom_range(0, 6));
    send_item(op, s[SIZE_W-1:0], al);
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (due_count != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_writes++;
    if (idx == CFG_CAPACITY) cap_now = val & 32'h1FFFFFF;
  endtask

  task automatic set_regs(input longint cap, input logic [31:0] ba, input logic [31:0] bb);
    drain_results();
    write_reg(CFG_CAPACITY, cap[31:0]);
    write_reg(CFG_BASE_A, ba);
    write_reg(CFG_BASE_B, bb);
  endtask

  task automatic run_phase(input longint cap, input logic [31:0] ba, input logic [31:0] bb,
                           input int count, input int gap);
    set_regs(cap, ba, bb);
    gap_pct = gap;
    repeat (count) send_random();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: tiny, padded and huge requests, saturating overruns
    gap_pct = 30;
    send_item(1'b0, 24'd0, 4'd0);
    send_item(1'b0, 24'd1, 4'd0);
    send_item(1'b0, 24'd17, 4'd5);
    send_item(1'b0, 24'd100, 4'd12);
    send_item(1'b0, 24'd5, 4'd15);
    repeat (4) send_item(1'b0, 24'hFFFFFF, 4'd15);
    send_item(1'b1, 24'hFFFFFF, 4'd15);
    send_item(1'b0, 24'hFFFFFF, 4'd0);   // fills the buffer exactly
    send_item(1'b0, 24'd0, 4'd4);        // empty grant at the very end
    send_item(1'b1, 24'd0, 4'd0);        // saturated offset folds into peak
    send_item(1'b1, 24'd0, 4'd0);

    // zero capacity, unaligned base a, base b near the top
    set_regs(0, 32'h1234_5678, 32'hFFFF_FFF0);
    send_item(1'b0, 24'd0, 4'd0);
    send_item(1'b0, 24'd0, 4'd5);
    send_item(1'b0, 24'd1, 4'd0);
    send_item(1'b1, 24'd0, 4'd0);
    send_item(1'b0, 24'd0, 4'd4);

    drain_results();
    write_reg(CFG_CAPACITY, 32'd1);
    send_item(1'b0, 24'd1, 4'd0);
    send_item(1'b0, 24'd2, 4'd0);

    // address wrap on buffer b, unaligned base a with a coarse alignment
    set_regs(64'd16777216, 32'h1234_5679, 32'hFFFF_FFF0);
    send_item(1'b0, 24'd64, 4'd0);
    send_item(1'b0, 24'd16, 4'd9);
    send_item(1'b1, 24'd0, 4'd0);
    send_item(1'b0, 24'd64, 4'd0);
    send_item(1'b0, 24'd16, 4'd9);

    run_phase(64'd16777216, $urandom() & 32'hFFFF_FFF0, $urandom() & 32'hFFFF_FFF0, 200, 20);
    run_phase(64'd4096, $urandom(), $urandom(), 75, 40);
    drain_results();
    repeat (75) send_random();
    run_phase(0, $urandom(), $urandom(), 60, 10);
    run_phase(1, $urandom(), $urandom(), 60, 20);
    run_phase(64'd33554431, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 150, 30);
    run_phase($urandom_range(1, 16777216), $urandom(), $urandom(), 200, 0);
    run_phase($urandom_range(1, 65536), $urandom(), $urandom(), 150, 25);
    quiet = 1'b1;
    run_phase(64'd16777216, 32'h0, 32'hFFFF_FFF0, 150, 0);

    drain_results();
    repeat (10) @(posedge clk);
    @(negedge clk);
    $display("summary: %0d items (%0d frame starts), %0d register writes", n_items, n_frames,
             n_writes);
    $display("summary: capacities 0, 1, 4096, 2^24, 2^25-1 and random; wrapped bases");
    if (fail_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/dbba_pkg.sv
rtl/dbba_front.sv
rtl/dbba_queue.sv
rtl/dbba_back.sv
rtl/double_buffered_bump_allocator.sv
rtl/dbba_checker.sv
bench/bump_alloc_checker.sv
bench/testbench.sv
